FILE: sv/lppt_pkg.sv
// Shared types and constants for the laser plane triangulator.
`default_nettype none
package lppt_pkg;

   localparam int DefFrameWidth  = 640;
   localparam int DefFrameHeight = 480;

   localparam int ColW = 10;
   localparam int RowW = 9;

   // Quotient width of the restoring divider; results above this are off the map anyway.
   localparam int QuoW   = 14;
   // Divisor is |den| or |den*32|: den fits in 53 bits, so the divisor fits in 58.
   localparam int DivW   = 58;
   // Dividends: numx below 2^63 in magnitude, numz below 2^52.
   localparam int NumW   = 63;

   localparam logic [2:0] RegNx    = 3'd0;
   localparam logic [2:0] RegNy    = 3'd1;
   localparam logic [2:0] RegNz    = 3'd2;
   localparam logic [2:0] RegOff   = 3'd3;
   localparam logic [2:0] RegInvF  = 3'd4;
   localparam logic [2:0] RegScale = 3'd5;

   typedef struct packed {
      logic [ColW-1:0] pixel_col;
      logic [RowW-1:0] pixel_row;
      logic            laser_hit;
   } req_payload_type;

   typedef struct packed {
      logic [ColW-1:0] map_col;
      logic [RowW-1:0] map_row;
   } rsp_payload_type;

   // One divider lane as it moves from cell to cell.
   typedef struct packed {
      logic            valid;
      logic            neg;
      logic [NumW-1:0] rem;
      logic [DivW-1:0] dvs;
      logic [QuoW-1:0] quo;
      logic            ovf;
   } div_lane_type;

   // Work carried alongside the two divider lanes.
   typedef struct packed {
      logic valid;
   } div_ctl_type;

endpackage
`default_nettype wire

FILE: sv/lppt_div_cell.sv
// One restoring divider cell: settles one quotient bit for both lanes per cycle unless stalled.
`default_nettype none
module lppt_div_cell #(
   parameter int Bit = 0
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   stall,
   input  lppt_pkg::div_lane_type x_in,
   input  lppt_pkg::div_lane_type z_in,
   output lppt_pkg::div_lane_type x_out,
   output lppt_pkg::div_lane_type z_out
);
   import lppt_pkg::*;

   div_lane_type x_ff, z_ff;

   function automatic div_lane_type step(input div_lane_type a);
      div_lane_type         r;
      logic [NumW+QuoW-1:0] sh;
      r  = a;
      sh = (NumW+QuoW)'(a.dvs) << Bit;
      if ({{QuoW{1'b0}}, a.rem} >= sh) begin
         r.rem = a.rem - sh[NumW-1:0];
         r.quo[Bit] = 1'b1;
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff.valid <= 1'b0;
         z_ff.valid <= 1'b0;
      end else if (!stall) begin
         x_ff <= step(x_in);
         z_ff <= step(z_in);
      end
   end

   assign x_out = x_ff;
   assign z_out = z_ff;
endmodule
`default_nettype wire

FILE: sv/lppt_front.sv
// Front stages: ray, dot product and numerators, then divider lane setup.
`default_nettype none
module lppt_front #(
   parameter int FrameWidth  = lppt_pkg::DefFrameWidth,
   parameter int FrameHeight = lppt_pkg::DefFrameHeight
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      stall,
   input  wire                      in_valid,
   input  lppt_pkg::req_payload_type in_data,
   input  wire signed [15:0]        nx,
   input  wire signed [15:0]        ny,
   input  wire signed [15:0]        nz,
   input  wire signed [20:0]        off,
   input  wire [15:0]               invf,
   input  wire [15:0]               scale,
   output lppt_pkg::div_lane_type   x_out,
   output lppt_pkg::div_lane_type   z_out
);
   import lppt_pkg::*;

   localparam int Cx = FrameWidth / 2;
   localparam int Cy = FrameHeight / 2;

   // Stage 1: ray components.
   logic               s1_v_ff;
   logic signed [30:0] ex_ff, ey_ff;
   // Stage 2: products of the dot product and partial numerators.
   logic               s2_v_ff;
   logic signed [47:0] px_ff, py_ff;
   logic signed [52:0] pz_ff;
   logic signed [30:0] ex2_ff;
   logic signed [37:0] ds_ff;
   // Stage 3: den and numerators.
   logic               s3_v_ff;
   logic signed [52:0] den_ff;
   logic signed [68:0] numx_ff;
   logic signed [52:0] numz_ff;

   logic signed [13:0] dx, dy;
   assign dx = 14'(Cx) - 14'(in_data.pixel_col);
   assign dy = 14'(Cy) - 14'(in_data.pixel_row);

   logic signed [52:0] den_in;
   assign den_in = 53'(px_ff) + 53'(py_ff) + pz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (!stall) begin
         s1_v_ff <= in_valid && in_data.laser_hit;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff && (den_in != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         ex_ff   <= 31'(dx * $signed({1'b0, invf}));
         ey_ff   <= 31'(dy * $signed({1'b0, invf}));
         px_ff   <= 48'(nx * ex_ff);
         py_ff   <= 48'(ny * ey_ff);
         pz_ff   <= 53'(nz) <<< 20;
         ex2_ff  <= ex_ff;
         ds_ff   <= 38'(-(38'(off)) * $signed({1'b0, scale}));
         den_ff  <= den_in;
         numx_ff <= 69'(ds_ff * ex2_ff);
         numz_ff <= 53'(ds_ff) <<< 15;
      end
   end

   // Stage 4: signs and magnitudes into the divider lanes.
   div_lane_type x_ff, z_ff;
   logic [52:0] aden;
   logic [68:0] anx;
   logic [52:0] anz;
   assign aden = den_ff[52] ? 53'(-den_ff) : den_ff;
   assign anx  = numx_ff[68] ? 69'(-numx_ff) : numx_ff;
   assign anz  = numz_ff[52] ? 53'(-numz_ff) : numz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff.valid <= 1'b0;
         z_ff.valid <= 1'b0;
      end else if (!stall) begin
         x_ff.valid <= s3_v_ff;
         z_ff.valid <= s3_v_ff;
         x_ff.neg   <= numx_ff[68] ^ den_ff[52];
         z_ff.neg   <= numz_ff[52] ^ den_ff[52];
         x_ff.rem   <= anx[NumW-1:0];
         z_ff.rem   <= NumW'(anz);
         x_ff.dvs   <= {aden, 5'd0};
         z_ff.dvs   <= DivW'(aden);
         x_ff.quo   <= '0;
         z_ff.quo   <= '0;
         // Quotient too large for the lane means surely off the map.
         x_ff.ovf   <= (anx >> QuoW) >= 69'({aden, 5'd0});
         z_ff.ovf   <= (69'(anz) >> QuoW) >= 69'(aden);
      end
   end

   assign x_out = x_ff;
   assign z_out = z_ff;
endmodule
`default_nettype wire

FILE: sv/laser_plane_pixel_triangulator.sv
// Top level: register file, pipeline of triangulation cells and output skid stage.
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | req_payload_type
//   rsp     | out       | rsp_valid/stall   | rsp_payload_type
//   csr     | in        | APB write/read    | six plane and map registers
// One pixel request per cycle unless stalled; 4 front stages, then 14 divider cells
// (one quotient bit each), then the output stage. Reset clears all valid bits and
// loads register defaults. A stalled result freezes the whole cell chain; a skid
// register keeps req_stall registered so it never depends on rsp_stall directly.
`default_nettype none
module laser_plane_pixel_triangulator #(
   parameter int FrameWidth  = lppt_pkg::DefFrameWidth,
   parameter int FrameHeight = lppt_pkg::DefFrameHeight
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  lppt_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output lppt_pkg::rsp_payload_type  rsp_payload,
   input  wire                        csr_psel,
   input  wire                        csr_penable,
   input  wire                        csr_pwrite,
   input  wire [4:0]                  csr_paddr,
   input  wire [31:0]                 csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import lppt_pkg::*;

   localparam int Cx = FrameWidth / 2;

   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic signed [20:0] off_ff;
   logic [15:0]        invf_ff, scale_ff;
   logic [2:0]         ridx;
   assign ridx = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff <= '0; ny_ff <= '0; nz_ff <= 16'sd32767; off_ff <= '0;
         invf_ff <= 16'd2474; scale_ff <= 16'd13107;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'd0) begin
         case (ridx)
            RegNx:    nx_ff    <= csr_pwdata[15:0];
            RegNy:    ny_ff    <= csr_pwdata[15:0];
            RegNz:    nz_ff    <= csr_pwdata[15:0];
            RegOff:   off_ff   <= csr_pwdata[20:0];
            RegInvF:  invf_ff  <= csr_pwdata[15:0];
            RegScale: scale_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         RegNx:    csr_prdata = 32'(nx_ff);
         RegNy:    csr_prdata = 32'(ny_ff);
         RegNz:    csr_prdata = 32'(nz_ff);
         RegOff:   csr_prdata = 32'(off_ff);
         RegInvF:  csr_prdata = {16'd0, invf_ff};
         RegScale: csr_prdata = {16'd0, scale_ff};
         default:  csr_prdata = '0;
      endcase
   end

   // Chain advances unless the skid register holds a result.
   logic chain_stall;
   logic out_v_ff, skid_v_ff;
   rsp_payload_type out_ff, skid_ff;

   assign chain_stall = skid_v_ff;
   assign req_stall   = skid_v_ff;

   div_lane_type lx [QuoW+1];
   div_lane_type lz [QuoW+1];

   lppt_front #(.FrameWidth(FrameWidth), .FrameHeight(FrameHeight)) u_front (
      .clock, .reset, .stall(chain_stall),
      .in_valid(req_valid), .in_data(req_payload),
      .nx(nx_ff), .ny(ny_ff), .nz(nz_ff), .off(off_ff),
      .invf(invf_ff), .scale(scale_ff),
      .x_out(lx[0]), .z_out(lz[0])
   );

   for (genvar g = 0; g < QuoW; g++) begin : g_cell
      lppt_div_cell #(.Bit(QuoW-1-g)) u_cell (
         .clock, .reset, .stall(chain_stall),
         .x_in(lx[g]), .z_in(lz[g]), .x_out(lx[g+1]), .z_out(lz[g+1])
      );
   end

   // Final range checks on the signed quotients.
   div_lane_type fx, fz;
   logic signed [QuoW+1:0] qx, qz, mx;
   logic keep;
   assign fx = lx[QuoW];
   assign fz = lz[QuoW];
   assign qx = fx.neg ? -$signed({2'b0, fx.quo}) : $signed({2'b0, fx.quo});
   assign qz = fz.neg ? -$signed({2'b0, fz.quo}) : $signed({2'b0, fz.quo});
   assign mx = qx + (QuoW+2)'(Cx);
   assign keep = fx.valid && !fx.ovf && !fz.ovf && mx >= 0
              && mx < (QuoW+2)'(FrameWidth) && qz >= 0 && qz < (QuoW+2)'(FrameHeight);

   rsp_payload_type fin;
   assign fin.map_col = mx[ColW-1:0];
   assign fin.map_row = qz[RowW-1:0];

   logic out_take;
   assign out_take = !out_v_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (out_take) begin
            if (skid_v_ff) begin
               out_v_ff  <= 1'b1;
               skid_v_ff <= 1'b0;
            end else begin
               out_v_ff <= keep;
            end
         end else if (!skid_v_ff && keep) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         out_ff <= skid_v_ff ? skid_ff : fin;
      end
      if (!skid_v_ff && !out_take && keep) begin
         skid_ff <= fin;
      end
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_payload = out_ff;

`ifndef ASSERT_OFF
   a_skid_only_when_held: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && rsp_stall)) else $error("skid filled without stall");
   a_req_stall_skid: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff) else $error("skid holds data with empty output");
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      keep |-> (fin.map_row < RowW'(FrameHeight) || FrameHeight > 480))
      else $error("row out of range");
`endif
endmodule
`default_nettype wire

FILE: tb/sv/laser_plane_pixel_triangulator_tb.sv
// Testbench for the laser plane triangulator: directed and random pixels checked against a fixed-point predictor.
`timescale 1ns / 1ps
module laser_plane_pixel_triangulator_tb;
   import lppt_pkg::*;

   localparam int HalfW = DefFrameWidth / 2;
   localparam int HalfH = DefFrameHeight / 2;
   localparam int StallLimit = 20000;

   class map_point_board;
      rsp_payload_type pending[$];
      longint nx, ny, nz, offs, invf, scl;
      int errors;

      function new();
         errors = 0;
         nx = 0; ny = 0; nz = 32767; offs = 0; invf = 2474; scl = 13107;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            RegNx:    nx = longint'(signed'(v[15:0]));
            RegNy:    ny = longint'(signed'(v[15:0]));
            RegNz:    nz = longint'(signed'(v[15:0]));
            RegOff:   offs = longint'(signed'(v[20:0]));
            RegInvF:  invf = longint'(v[15:0]);
            RegScale: scl = longint'(v[15:0]);
            default: ;
         endcase
      endfunction

      // Intersects the pixel ray with the plane; only on-map points produce a result.
      function void note_request(req_payload_type p);
         longint ex, ey, den, numx, numz, mx, mz;
         rsp_payload_type r;
         if (!p.laser_hit) return;
         ex = (HalfW - longint'(p.pixel_col)) * invf;
         ey = (HalfH - longint'(p.pixel_row)) * invf;
         den = nx * ex + ny * ey + nz * (longint'(1) << 20);
         if (den == 0) return;
         numx = (-offs) * ex * scl;
         numz = (-offs) * scl * (longint'(1) << 15);
         mx = numx / (den * 32) + HalfW;
         mz = numz / den;
         if (mx < 0 || mx >= DefFrameWidth || mz < 0 || mz >= DefFrameHeight) return;
         r.map_col = mx[ColW-1:0];
         r.map_row = mz[RowW-1:0];
         pending = {pending, r};
      endfunction

      function void check_result(rsp_payload_type a);
         rsp_payload_type e;
         if (pending.size() == 0) begin
            $error("unexpected map point col=%0d row=%0d", a.map_col, a.map_row);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.map_col !== e.map_col) begin
            $error("map_col expected %0d actual %0d", e.map_col, a.map_col);
            errors++;
         end
         if (a.map_row !== e.map_row) begin
            $error("map_row expected %0d actual %0d", e.map_row, a.map_row);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [4:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   map_point_board board = new();
   int send_idle_pct, recv_stall_pct;
   bit hold_rsp;
   int quiet_cycles;

   laser_plane_pixel_triangulator dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Receiver: random stalls, or a long hold-off while hold_rsp is set.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_rsp || ($urandom_range(99) < recv_stall_pct);
         if (rsp_valid && !rsp_stall) board.check_result(rsp_payload);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("laser_plane_pixel_triangulator: mismatch");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] v);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.set_reg(idx, v);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   // Drives one request; an idle gap may come first, valid stays high across back-to-back items.
   task automatic send_pixel(logic [9:0] col, logic [8:0] row, logic hit);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid <= 1;
      req_payload <= '{pixel_col: col, pixel_row: row, laser_hit: hit};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request('{pixel_col: col, pixel_row: row, laser_hit: hit});
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_pixel();
      logic [9:0] c;
      logic [8:0] r;
      case ($urandom_range(9))
         0: c = $urandom;
         default: c = $urandom_range(639);
      endcase
      r = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(479));
      send_pixel(c, r, $urandom_range(9) != 0);
   endtask

   // Plane that looks down-forward, so many pixels land on the map.
   task automatic realistic_plane();
      write_reg(RegNx, 32'($urandom_range(4000)) - 2000);
      write_reg(RegNy, 32'($urandom_range(30000, 8000)));
      write_reg(RegNz, 32'($urandom_range(20000)) - 10000);
      write_reg(RegOff, -32'($urandom_range(40000, 2000)));
      write_reg(RegInvF, $urandom_range(4000, 1000));
      write_reg(RegScale, $urandom_range(30000, 5000));
   endtask

   initial begin
      req_valid = 0; req_payload = '0; rsp_stall = 0; hold_rsp = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      send_idle_pct = 0; recv_stall_pct = 0;
      reset = 1;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Defaults give zero offset, so every laser pixel maps to the centre column.
      send_pixel(0, 0, 1);
      send_pixel(639, 479, 1);
      send_pixel(1023, 511, 1);
      send_pixel(320, 240, 0);
      send_pixel(320, 240, 1);
      drain();
      // Parallel ray: normal z zero and pixel on the optical centre give a zero dot product.
      write_reg(RegNx, 32'h7fff); write_reg(RegNy, 32'h8000); write_reg(RegNz, 0);
      write_reg(RegOff, 32'h100000); write_reg(RegInvF, 16'hffff);
      write_reg(RegScale, 16'hffff);
      send_pixel(320, 240, 1);
      send_pixel(0, 479, 1);
      send_pixel(639, 0, 1);
      send_pixel(1023, 0, 1);
      drain();
      write_reg(RegNx, 0); write_reg(RegNy, 32'h7fff); write_reg(RegNz, 32'h1000);
      write_reg(RegOff, 32'hfff00000); write_reg(RegInvF, 2474); write_reg(RegScale, 0);
      for (int i = 0; i < 8; i++) send_pixel(10'(i * 80), 9'(250 + i * 25), 1);
      drain();
      write_reg(RegOff, 32'h000fffff); write_reg(RegScale, 13107);
      for (int i = 0; i < 6; i++) send_pixel(10'(i * 120), 9'(i * 90), 1);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
         endcase
         if (ph == 7) begin
            write_reg(RegNx, $urandom); write_reg(RegNy, $urandom);
            write_reg(RegNz, $urandom); write_reg(RegOff, $urandom);
            write_reg(RegInvF, $urandom); write_reg(RegScale, $urandom);
         end else begin
            realistic_plane();
         end
         if (ph == 2) begin
            // Long receiver hold-off while pixels keep coming, so the pipeline backs up.
            fork
               begin
                  hold_rsp = 1;
                  repeat (200) @(posedge clock);
                  hold_rsp = 0;
               end
               for (int i = 0; i < 60; i++) send_pixel($urandom_range(639), 300, 1);
            join
         end
         for (int i = 0; i < 150; i++) random_pixel();
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("laser_plane_pixel_triangulator: match");
      end else begin
         if (board.pending.size() != 0) $error("%0d map points never arrived",
                                               board.pending.size());
         $display("laser_plane_pixel_triangulator: mismatch");
      end
      $finish;
   end
endmodule

FILE: filelist.f
sv/lppt_pkg.sv
sv/lppt_div_cell.sv
sv/lppt_front.sv
sv/laser_plane_pixel_triangulator.sv
tb/sv/laser_plane_pixel_triangulator_tb.sv
